// ===== rtl/core/trm_pkg.sv =====
// ----------------------------------------------------------------------------
// trm_pkg
// Shared widths, codes and types of the thrust/rudder mixer.
// ----------------------------------------------------------------------------
package trm_pkg;

   localparam int START_GRACE_TICKS = 1000;
   localparam int FULL_SCALE        = 1000;
   localparam int AGE_CAP           = 65535;

   localparam int KIND_W     = 2;
   localparam int VALUE_W    = 16;
   localparam int DRIVE_W    = 11;
   localparam int RUD_W      = 12;
   localparam int CNT_W      = 16;
   localparam int AGE_W      = 17;
   localparam int MR_W       = 11;
   localparam int MT_W       = 10;
   localparam int ST_W       = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_THRUST  = 2'd0,
      KIND_RUDDER  = 2'd1,
      KIND_ALLSTOP = 2'd2,
      KIND_TICK    = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RUDDER_LIM  = 2'd0,
      CSR_DRIVE_LIM   = 2'd1,
      CSR_STALE_TICKS = 2'd2
   } csr_index_type;

   localparam logic [MR_W-1:0] RUDDER_LIM_RESET  = MR_W'(500);
   localparam logic [MT_W-1:0] DRIVE_LIM_RESET   = MT_W'(1000);
   localparam logic [ST_W-1:0] STALE_TICKS_RESET = ST_W'(150);

   // one tick's worth of mixing work, already past the staleness check
   typedef struct packed {
      logic signed [DRIVE_W-1:0] thrust;
      logic signed [RUD_W-1:0]   rudder;
      logic                      stale;
      logic                      newly_stale;
      logic [CNT_W-1:0]          stale_events;
   } mix_job_type;

endpackage

// ===== rtl/core/trm_if.sv =====
// ----------------------------------------------------------------------------
// trm interfaces
// Valid/ready channels for commands, drive results and register writes.
// ----------------------------------------------------------------------------
interface trm_req_if;
   import trm_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [KIND_W-1:0]          kind;
   logic signed [VALUE_W-1:0]  value;
   logic                       allstop_clear;
   modport source (output valid, kind, value, allstop_clear, input ready);
   modport sink   (input valid, kind, value, allstop_clear, output ready);
endinterface

interface trm_rsp_if;
   import trm_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [DRIVE_W-1:0]  left_drive;
   logic signed [DRIVE_W-1:0]  right_drive;
   logic                       stale;
   logic                       newly_stale;
   logic [CNT_W-1:0]           stale_events;
   modport source (output valid, left_drive, right_drive, stale, newly_stale, stale_events,
                   input ready);
   modport sink   (input valid, left_drive, right_drive, stale, newly_stale, stale_events,
                   output ready);
endinterface

interface trm_csr_if;
   import trm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/thrust_rudder_mixer_with_timeout.sv =====
// ----------------------------------------------------------------------------
// thrust_rudder_mixer_with_timeout
// Differential drive mixer with a command timeout, top level.
// ----------------------------------------------------------------------------
// req_ch carries thrust and rudder commands, allstop words and ticks; csr_ch
// writes the rudder limit (0), the drive limit (1) and stale_ticks (2), always
// ready. Commands and allstop words update state and give no result. Each tick
// runs the timeout check in the front and leaves one rsp_ch word with left and
// right drive and the stale flags.
// One word is taken every cycle while the queue has room. A tick accepted
// is written to a queue entry, then passes the back pipeline's product
// stage, reciprocal divide stage and the overage/clamp stage feeding rsp_ch.
// A two-word queue sits between front and back; when rsp_ch stalls the
// pipeline fills, then the queue, and only then does req_ch.ready fall.
// Commands and allstop words are taken even with the back stalled, unless
// the queue is full.
// Synchronous reset returns registers to their defaults, allstop engaged,
// commands zero and both ages at minus the start grace; no clearing pass.
// ----------------------------------------------------------------------------
module thrust_rudder_mixer_with_timeout (
   input  logic        clock,
   input  logic        reset,
   trm_req_if.sink     req_ch,
   trm_rsp_if.source   rsp_ch,
   trm_csr_if.sink     csr_ch
);
   import trm_pkg::*;

   logic          job_push;
   mix_job_type   push_job;
   logic          queue_full;
   logic          head_valid;
   mix_job_type   head_job;
   logic          job_pop;
   logic [MT_W-1:0] drive_lim;

   trm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job        (push_job),
      .drive_lim  (drive_lim)
   );

   trm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .pop        (job_pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   trm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (head_valid),
      .job        (head_job),
      .drive_lim  (drive_lim),
      .job_pop    (job_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ===== rtl/core/trm_front.sv =====
// ----------------------------------------------------------------------------
// trm_front
// Takes command, allstop and tick words, keeps command state and ages,
// runs the timeout check on ticks and hands clamped commands to the queue.
// ----------------------------------------------------------------------------
module trm_front (
   input  logic                       clock,
   input  logic                       reset,
   trm_req_if.sink                    req_ch,
   trm_csr_if.sink                    csr_ch,
   input  logic                       queue_full,
   output logic                       job_push,
   output trm_pkg::mix_job_type       job,
   output logic [trm_pkg::MT_W-1:0]   drive_lim
);
   import trm_pkg::*;

   localparam logic signed [AGE_W-1:0]   AGE_RESET  = AGE_W'(-START_GRACE_TICKS);
   localparam logic signed [AGE_W-1:0]   AGE_TOP    = AGE_W'(AGE_CAP);
   localparam logic signed [VALUE_W-1:0] THRUST_LIM = VALUE_W'(FULL_SCALE);

   logic [MR_W-1:0]            rudder_lim_ff, rudder_lim_in;
   logic [MT_W-1:0]            drive_lim_ff, drive_lim_in;
   logic [ST_W-1:0]            stale_ticks_ff, stale_ticks_in;
   logic signed [VALUE_W-1:0]  thrust_cmd_ff, thrust_cmd_in;
   logic signed [VALUE_W-1:0]  rudder_cmd_ff, rudder_cmd_in;
   logic signed [AGE_W-1:0]    thrust_age_ff, thrust_age_in;
   logic signed [AGE_W-1:0]    rudder_age_ff, rudder_age_in;
   logic                       allstop_ff, allstop_in;
   logic                       armed_ff, armed_in;
   logic                       stale_mode_ff, stale_mode_in;
   logic [CNT_W-1:0]           stale_count_ff, stale_count_in;

   logic                       req_accept;
   logic                       csr_write;
   logic signed [AGE_W-1:0]    thrust_age_step, rudder_age_step;
   logic signed [AGE_W-1:0]    stale_limit;
   logic                       tick_stale, tick_newly;
   logic [CNT_W-1:0]           stale_count_tick;
   logic signed [VALUE_W-1:0]  thrust_live, rudder_live, thrust_clamped;
   logic signed [AGE_W-1:0]    rudder_limit, rudder_wide, rudder_clamped;

   assign req_ch.ready = !queue_full;
   assign csr_ch.ready = 1'b1;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_write    = csr_ch.valid && csr_ch.ready;
   assign drive_lim    = drive_lim_ff;

   // ages advance before the compare, saturating at the cap
   assign thrust_age_step = (thrust_age_ff < AGE_TOP) ? thrust_age_ff + AGE_W'(1) : AGE_TOP;
   assign rudder_age_step = (rudder_age_ff < AGE_TOP) ? rudder_age_ff + AGE_W'(1) : AGE_TOP;
   assign stale_limit     = $signed({1'b0, stale_ticks_ff});

   assign tick_stale = !allstop_ff && armed_ff &&
                       ((rudder_age_step > stale_limit) || (thrust_age_step > stale_limit));
   assign tick_newly = tick_stale && !stale_mode_ff;
   assign stale_count_tick = (tick_newly && (stale_count_ff != '1)) ?
                             stale_count_ff + CNT_W'(1) : stale_count_ff;

   // commands as the mix sees them on this tick
   assign thrust_live = tick_stale ? '0 : thrust_cmd_ff;
   assign rudder_live = tick_stale ? '0 : rudder_cmd_ff;

   always_comb begin
      if (thrust_live > THRUST_LIM) begin
         thrust_clamped = THRUST_LIM;
      end else if (thrust_live < -THRUST_LIM) begin
         thrust_clamped = -THRUST_LIM;
      end else begin
         thrust_clamped = thrust_live;
      end
   end

   assign rudder_limit = $signed({{(AGE_W-MR_W){1'b0}}, rudder_lim_ff});
   assign rudder_wide  = AGE_W'(rudder_live);

   always_comb begin
      if (rudder_wide > rudder_limit) begin
         rudder_clamped = rudder_limit;
      end else if (rudder_wide < -rudder_limit) begin
         rudder_clamped = -rudder_limit;
      end else begin
         rudder_clamped = rudder_wide;
      end
   end

   assign job_push         = req_accept && (kind_type'(req_ch.kind) == KIND_TICK);
   assign job.thrust       = thrust_clamped[DRIVE_W-1:0];
   assign job.rudder       = rudder_clamped[RUD_W-1:0];
   assign job.stale        = tick_stale;
   assign job.newly_stale  = tick_newly;
   assign job.stale_events = stale_count_tick;

   always_comb begin
      rudder_lim_in  = rudder_lim_ff;
      drive_lim_in   = drive_lim_ff;
      stale_ticks_in = stale_ticks_ff;
      if (csr_write) begin
         unique case (csr_ch.index)
            CSR_RUDDER_LIM:  rudder_lim_in  = csr_ch.data[MR_W-1:0];
            CSR_DRIVE_LIM:   drive_lim_in   = csr_ch.data[MT_W-1:0];
            CSR_STALE_TICKS: stale_ticks_in = csr_ch.data[ST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      thrust_cmd_in  = thrust_cmd_ff;
      rudder_cmd_in  = rudder_cmd_ff;
      thrust_age_in  = thrust_age_ff;
      rudder_age_in  = rudder_age_ff;
      allstop_in     = allstop_ff;
      armed_in       = armed_ff;
      stale_mode_in  = stale_mode_ff;
      stale_count_in = stale_count_ff;
      if (req_accept) begin
         unique case (kind_type'(req_ch.kind))
            KIND_THRUST: begin
               thrust_cmd_in = req_ch.value;
               thrust_age_in = '0;
               if (req_ch.value > 16'sd0) armed_in = 1'b1;
            end
            KIND_RUDDER: begin
               rudder_cmd_in = req_ch.value;
               rudder_age_in = '0;
               if (req_ch.value > 16'sd0) armed_in = 1'b1;
            end
            KIND_ALLSTOP: begin
               allstop_in = !req_ch.allstop_clear;
            end
            KIND_TICK: begin
               thrust_age_in  = thrust_age_step;
               rudder_age_in  = rudder_age_step;
               thrust_cmd_in  = thrust_live;
               rudder_cmd_in  = rudder_live;
               stale_mode_in  = tick_stale;
               stale_count_in = stale_count_tick;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rudder_lim_ff  <= RUDDER_LIM_RESET;
         drive_lim_ff   <= DRIVE_LIM_RESET;
         stale_ticks_ff <= STALE_TICKS_RESET;
         thrust_cmd_ff  <= '0;
         rudder_cmd_ff  <= '0;
         thrust_age_ff  <= AGE_RESET;
         rudder_age_ff  <= AGE_RESET;
         allstop_ff     <= 1'b1;
         armed_ff       <= 1'b0;
         stale_mode_ff  <= 1'b0;
         stale_count_ff <= '0;
      end else begin
         rudder_lim_ff  <= rudder_lim_in;
         drive_lim_ff   <= drive_lim_in;
         stale_ticks_ff <= stale_ticks_in;
         thrust_cmd_ff  <= thrust_cmd_in;
         rudder_cmd_ff  <= rudder_cmd_in;
         thrust_age_ff  <= thrust_age_in;
         rudder_age_ff  <= rudder_age_in;
         allstop_ff     <= allstop_in;
         armed_ff       <= armed_in;
         stale_mode_ff  <= stale_mode_in;
         stale_count_ff <= stale_count_in;
      end
   end

endmodule

// ===== rtl/core/trm_queue.sv =====
// ----------------------------------------------------------------------------
// trm_queue
// Short first-in first-out queue of mix jobs between front and back.
// ----------------------------------------------------------------------------
module trm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  trm_pkg::mix_job_type  push_job,
   input  logic                  pop,
   output logic                  full,
   output logic                  head_valid,
   output trm_pkg::mix_job_type  head_job
);
   import trm_pkg::*;

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   mix_job_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/trm_back.sv =====
// ----------------------------------------------------------------------------
// trm_back
// Three-stage mix pipeline: scale product, divide by full scale,
// overage transfer and clamp into the result register.
// ----------------------------------------------------------------------------
module trm_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   input  trm_pkg::mix_job_type       job,
   input  logic [trm_pkg::MT_W-1:0]   drive_lim,
   output logic                       job_pop,
   trm_rsp_if.source                  rsp_ch
);
   import trm_pkg::*;

   localparam int SUM_W       = RUD_W + 1;
   localparam int MAG_W       = SUM_W - 1;
   localparam int PROD_W      = MAG_W + MT_W;
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 23;
   // ceil(2^32 / 1000), exact for every product below about six million
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(4294968);
   localparam int FULL_W      = PROD_W + RECIP_W;
   localparam int QUO_W       = FULL_W - RECIP_SHIFT;
   localparam int SCALED_W    = QUO_W + 1;
   localparam int MIX_W       = 16;

   typedef struct packed {
      logic [PROD_W-1:0] prod_left;
      logic [PROD_W-1:0] prod_right;
      logic              neg_left;
      logic              neg_right;
      logic              stale;
      logic              newly_stale;
      logic [CNT_W-1:0]  stale_events;
   } scale_stage_type;

   typedef struct packed {
      logic signed [SCALED_W-1:0] left;
      logic signed [SCALED_W-1:0] right;
      logic                       stale;
      logic                       newly_stale;
      logic [CNT_W-1:0]           stale_events;
   } quot_stage_type;

   scale_stage_type  s1_ff, s1_in;
   quot_stage_type   s2_ff, s2_in;
   logic             s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic             out_free, s2_free, s1_free;

   logic signed [SUM_W-1:0]   sum_left, sum_right;
   logic [MAG_W-1:0]          mag_left, mag_right;
   logic [FULL_W-1:0]         full_left, full_right;
   logic [QUO_W-1:0]          quo_left, quo_right;
   logic signed [MIX_W-1:0]   mt_pos, side_left, side_right;
   logic signed [MIX_W-1:0]   over_left, right_adj, over_right, left_adj;
   logic signed [MIX_W-1:0]   left_fin, right_fin;

   logic signed [DRIVE_W-1:0] left_ff, right_ff;
   logic                      stale_ff, newly_ff;
   logic [CNT_W-1:0]          events_ff;

   // each stage moves on when the one after it has room
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign job_pop  = job_valid && s1_free;

   // stage 1: side sums and scale products
   assign sum_left  = SUM_W'(job.thrust) + SUM_W'(job.rudder);
   assign sum_right = SUM_W'(job.thrust) - SUM_W'(job.rudder);
   assign mag_left  = sum_left[SUM_W-1]  ? MAG_W'(-sum_left)  : MAG_W'(sum_left);
   assign mag_right = sum_right[SUM_W-1] ? MAG_W'(-sum_right) : MAG_W'(sum_right);

   always_comb begin
      s1_in.prod_left    = PROD_W'(mag_left) * PROD_W'(drive_lim);
      s1_in.prod_right   = PROD_W'(mag_right) * PROD_W'(drive_lim);
      s1_in.neg_left     = sum_left[SUM_W-1];
      s1_in.neg_right    = sum_right[SUM_W-1];
      s1_in.stale        = job.stale;
      s1_in.newly_stale  = job.newly_stale;
      s1_in.stale_events = job.stale_events;
   end

   // stage 2: divide by full scale, truncating toward zero
   assign full_left  = FULL_W'(s1_ff.prod_left) * FULL_W'(RECIP);
   assign full_right = FULL_W'(s1_ff.prod_right) * FULL_W'(RECIP);
   assign quo_left   = full_left[FULL_W-1:RECIP_SHIFT];
   assign quo_right  = full_right[FULL_W-1:RECIP_SHIFT];

   always_comb begin
      s2_in.left         = s1_ff.neg_left  ? -$signed({1'b0, quo_left})  : $signed({1'b0, quo_left});
      s2_in.right        = s1_ff.neg_right ? -$signed({1'b0, quo_right}) : $signed({1'b0, quo_right});
      s2_in.stale        = s1_ff.stale;
      s2_in.newly_stale  = s1_ff.newly_stale;
      s2_in.stale_events = s1_ff.stale_events;
   end

   // stage 3: push overage across, then clamp both sides
   assign mt_pos     = $signed({{(MIX_W-MT_W){1'b0}}, drive_lim});
   assign side_left  = MIX_W'(s2_ff.left);
   assign side_right = MIX_W'(s2_ff.right);

   always_comb begin
      if (side_left > mt_pos) begin
         over_left = side_left - mt_pos;
      end else if (side_left < -mt_pos) begin
         over_left = side_left + mt_pos;
      end else begin
         over_left = '0;
      end
      right_adj = side_right - over_left;
      if (right_adj > mt_pos) begin
         over_right = right_adj - mt_pos;
      end else if (right_adj < -mt_pos) begin
         over_right = right_adj + mt_pos;
      end else begin
         over_right = '0;
      end
      left_adj = side_left - over_right;

      if (left_adj > mt_pos) begin
         left_fin = mt_pos;
      end else if (left_adj < -mt_pos) begin
         left_fin = -mt_pos;
      end else begin
         left_fin = left_adj;
      end
      if (right_adj > mt_pos) begin
         right_fin = mt_pos;
      end else if (right_adj < -mt_pos) begin
         right_fin = -mt_pos;
      end else begin
         right_fin = right_adj;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_ff <= s1_in;
      end
      if (s2_free) begin
         s2_ff <= s2_in;
      end
      if (out_free) begin
         left_ff   <= left_fin[DRIVE_W-1:0];
         right_ff  <= right_fin[DRIVE_W-1:0];
         stale_ff  <= s2_ff.stale;
         newly_ff  <= s2_ff.newly_stale;
         events_ff <= s2_ff.stale_events;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free)  s1_valid_ff  <= job_valid;
         if (s2_free)  s2_valid_ff  <= s1_valid_ff;
         if (out_free) rsp_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.left_drive   = left_ff;
   assign rsp_ch.right_drive  = right_ff;
   assign rsp_ch.stale        = stale_ff;
   assign rsp_ch.newly_stale  = newly_ff;
   assign rsp_ch.stale_events = events_ff;

endmodule

// ===== rtl/core/trm_checker.sv =====
// ----------------------------------------------------------------------------
// trm_checker
// Port-level checks on the mixer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module trm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [trm_pkg::DRIVE_W-1:0] left_drive,
   input logic signed [trm_pkg::DRIVE_W-1:0] right_drive,
   input logic                               stale,
   input logic                               newly_stale,
   input logic [trm_pkg::CNT_W-1:0]          stale_events
);

   // after reset nothing is in flight and the queue has room
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("pipeline not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(left_drive) &&
         $stable(right_drive) && $stable(stale) && $stable(newly_stale) &&
         $stable(stale_events)))
      else $error("stalled result word changed");

   a_newly_implies_stale: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && newly_stale) |-> stale)
      else $error("newly_stale without stale");

   // a fresh-to-stale word always has a non-zero event count
   a_newly_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && newly_stale) |-> (stale_events != '0))
      else $error("transition not counted");

endmodule

bind thrust_rudder_mixer_with_timeout trm_checker u_trm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .left_drive   (rsp_ch.left_drive),
   .right_drive  (rsp_ch.right_drive),
   .stale        (rsp_ch.stale),
   .newly_stale  (rsp_ch.newly_stale),
   .stale_events (rsp_ch.stale_events)
);
